// ===== rtl/core/elfnsp_pkg.sv =====
// elfnsp_pkg: shared types, codes and name tables for the note stream parser
// no dependencies; used by elf_note_stream_parser_unit
package elfnsp_pkg;

  localparam int COUNT_WIDTH_DEF = 32;

  localparam int WORD_W  = 32;
  localparam int ROLE_W  = 3;
  localparam int CLASS_W = 3;
  localparam int STAT_W  = 2;
  localparam int IDX_W   = 2;
  localparam int NAME_COUNT = 5;
  localparam int HDR_BYTES  = 12;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_BIG_ENDIAN  = 2'd0;
  localparam logic [IDX_W-1:0] REG_REGION_SIZE = 2'd1;

  // byte roles
  localparam logic [ROLE_W-1:0] ROLE_HEADER   = 3'd0;
  localparam logic [ROLE_W-1:0] ROLE_NAME     = 3'd1;
  localparam logic [ROLE_W-1:0] ROLE_NAME_PAD = 3'd2;
  localparam logic [ROLE_W-1:0] ROLE_DESC     = 3'd3;
  localparam logic [ROLE_W-1:0] ROLE_DESC_PAD = 3'd4;
  localparam logic [ROLE_W-1:0] ROLE_IGNORED  = 3'd5;

  // name classes
  localparam logic [CLASS_W-1:0] CLASS_OTHER      = 3'd0;

  // parse status
  localparam logic [STAT_W-1:0] STATUS_RUNNING = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_CLEAN   = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_TRUNC   = 2'd2;

  typedef enum logic [5:0] {
    PH_HDR  = 6'b000001,
    PH_NAME = 6'b000010,
    PH_NPAD = 6'b000100,
    PH_DESC = 6'b001000,
    PH_DPAD = 6'b010000,
    PH_STOP = 6'b100000
  } phase_t;

  // known names, right aligned, one byte per character
  localparam logic [127:0] NAME_VMCI     = 128'h0000_0000_0000_564d_434f_5245_494e_464f;
  localparam logic [127:0] NAME_VMCI_HV  = 128'h0000_564d_434f_5245_494e_464f_5f58_454e;
  localparam logic [127:0] NAME_CORE     = 128'h0000_0000_0000_0000_0000_0000_434f_5245;
  localparam logic [127:0] NAME_HV       = 128'h0000_0000_0000_0000_0000_0000_0058_656e;
  localparam logic [127:0] NAME_NOTE_HV  = 128'h0000_0000_0000_2e6e_6f74_652e_5865_6e;

  function automatic logic [4:0] known_len(input logic [2:0] k);
    logic [4:0] r;
    case (k)
      3'd0:    r = 5'd10;
      3'd1:    r = 5'd14;
      3'd2:    r = 5'd4;
      3'd3:    r = 5'd3;
      3'd4:    r = 5'd9;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  // expected character at position i of known name k, zero past its end
  function automatic logic [7:0] known_char(input logic [2:0] k, input logic [3:0] i);
    logic [127:0] s;
    logic [4:0]   len;
    int           base;
    case (k)
      3'd0:    s = NAME_VMCI;
      3'd1:    s = NAME_VMCI_HV;
      3'd2:    s = NAME_CORE;
      3'd3:    s = NAME_HV;
      3'd4:    s = NAME_NOTE_HV;
      default: s = '0;
    endcase
    len = known_len(k);
    base = 8 * (int'(len) - 1 - int'(i));
    if ({1'b0, i} < len) begin
      return s[base +: 8];
    end
    return 8'd0;
  endfunction

  // bytes needed to round n up to a multiple of four
  function automatic logic [1:0] pad_of(input logic [WORD_W-1:0] n);
    logic [1:0] r;
    r = 2'd0 - n[1:0];
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] swap32(input logic [WORD_W-1:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

  // lowest surviving candidate wins
  function automatic logic [CLASS_W-1:0] class_of(input logic [NAME_COUNT-1:0] f);
    logic [CLASS_W-1:0] r;
    r = CLASS_OTHER;
    for (int k = NAME_COUNT - 1; k >= 0; k--) begin
      if (f[k]) begin
        r = CLASS_W'(k + 1);
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/elf_note_stream_parser_unit.sv =====
// elf_note_stream_parser_unit: byte-serial note region parser with registered result
// depends on elfnsp_pkg
// the result of a transferred byte appears on the output register in the next cycle
// throughput: one byte per cycle; a byte waits only while the held result is stalled
// reset: synchronous; header phase, little endian, zero region size so bytes end
// cleanly until region_size is written
module elf_note_stream_parser_unit #(
  parameter int COUNT_WIDTH = elfnsp_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [elfnsp_pkg::IDX_W-1:0]        cfg_index,
  input  logic [elfnsp_pkg::WORD_W-1:0]       cfg_data,
  // byte input
  input  logic                                byte_valid,
  output logic                                byte_stall,
  input  logic [7:0]                          data_byte,
  // result output
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [elfnsp_pkg::ROLE_W-1:0]       byte_role,
  output logic [elfnsp_pkg::WORD_W-1:0]       note_type,
  output logic [elfnsp_pkg::CLASS_W-1:0]      name_class,
  output logic [elfnsp_pkg::WORD_W-1:0]       desc_size,
  output logic [elfnsp_pkg::WORD_W-1:0]       desc_offset,
  output logic                                note_complete,
  output logic [elfnsp_pkg::STAT_W-1:0]       parse_status
);

  localparam int CW = COUNT_WIDTH;
  // wide enough for any count and for name + pad + descriptor
  localparam int XW = (CW > 34) ? CW : 34;
  localparam int NC = elfnsp_pkg::NAME_COUNT;
  localparam int WW = elfnsp_pkg::WORD_W;

  logic                         big_endian;
  elfnsp_pkg::phase_t           phase, phase_next;
  logic [CW-1:0]                field_count, field_count_next;
  logic [CW-1:0]                bytes_left, bytes_left_next;
  logic [WW-1:0]                word_assembly, word_assembly_next;
  logic [WW-1:0]                name_length, name_length_next;
  logic [WW-1:0]                desc_length, desc_length_next;
  logic [WW-1:0]                type_word, type_word_next;
  logic [NC-1:0]                match_flags, match_flags_next;
  logic [elfnsp_pkg::STAT_W-1:0] stop_state, stop_state_next;

  logic [elfnsp_pkg::ROLE_W-1:0]  role_c;
  logic [elfnsp_pkg::CLASS_W-1:0] cls_c;
  logic [WW-1:0]                  ntype_c, dsize_c, doff_c;
  logic                           complete_c;

  logic [CW-1:0] fc_inc, bl_dec;
  logic [WW-1:0] word_val;
  logic [XW-1:0] need;
  logic [XW-1:0] sat_size;

  logic byte_xfer, cfg_xfer;

  assign cfg_ready  = 1'b1;
  assign cfg_xfer   = cfg_valid & cfg_ready;
  assign byte_stall = result_valid & result_stall;
  assign byte_xfer  = byte_valid & ~byte_stall;

  // first non-empty section after section rank p (0 header, 1 name, 2 name pad, 3 desc)
  function automatic elfnsp_pkg::phase_t enter_after(input logic [1:0] p,
                                                     input logic [WW-1:0] nl,
                                                     input logic [WW-1:0] dl,
                                                     input logic bl_nz);
    elfnsp_pkg::phase_t r;
    if (p < 2'd1 && nl != '0) begin
      r = elfnsp_pkg::PH_NAME;
    end else if (p < 2'd2 && elfnsp_pkg::pad_of(nl) != 2'd0) begin
      r = elfnsp_pkg::PH_NPAD;
    end else if (p < 2'd3 && dl != '0) begin
      r = elfnsp_pkg::PH_DESC;
    end else if (elfnsp_pkg::pad_of(dl) != 2'd0 && bl_nz) begin
      r = elfnsp_pkg::PH_DPAD;
    end else begin
      r = elfnsp_pkg::PH_HDR;
    end
    return r;
  endfunction

  always_comb begin
    phase_next         = phase;
    field_count_next   = field_count;
    bytes_left_next    = bytes_left;
    word_assembly_next = word_assembly;
    name_length_next   = name_length;
    desc_length_next   = desc_length;
    type_word_next     = type_word;
    match_flags_next   = match_flags;
    stop_state_next    = stop_state;

    role_c     = elfnsp_pkg::ROLE_IGNORED;
    cls_c      = elfnsp_pkg::CLASS_OTHER;
    ntype_c    = '0;
    dsize_c    = '0;
    doff_c     = '0;
    complete_c = 1'b0;

    fc_inc   = field_count + CW'(1);
    bl_dec   = (bytes_left != '0) ? bytes_left - CW'(1) : bytes_left;
    word_val = '0;
    need     = XW'(name_length) + XW'(elfnsp_pkg::pad_of(name_length)) + XW'(desc_length);

    if (phase == elfnsp_pkg::PH_STOP) begin
      role_c = elfnsp_pkg::ROLE_IGNORED;
    end else if (phase == elfnsp_pkg::PH_HDR && field_count == '0 &&
                 XW'(bytes_left) < XW'(elfnsp_pkg::HDR_BYTES)) begin
      phase_next      = elfnsp_pkg::PH_STOP;
      stop_state_next = elfnsp_pkg::STATUS_CLEAN;
    end else begin
      bytes_left_next = bl_dec;
      case (phase)
        elfnsp_pkg::PH_HDR: begin
          role_c = elfnsp_pkg::ROLE_HEADER;
          word_assembly_next = {word_assembly[WW-9:0], data_byte};
          word_val = big_endian ? word_assembly_next : elfnsp_pkg::swap32(word_assembly_next);
          if (field_count[1:0] == 2'd3) begin
            if ((field_count >> 2) == CW'(0)) begin
              name_length_next = word_val;
            end else if ((field_count >> 2) == CW'(1)) begin
              desc_length_next = word_val;
            end else begin
              type_word_next = word_val;
            end
          end
          field_count_next = fc_inc;
          if (fc_inc == CW'(elfnsp_pkg::HDR_BYTES)) begin
            ntype_c = type_word_next;
            dsize_c = desc_length_next;
            if (XW'(bl_dec) < need) begin
              phase_next      = elfnsp_pkg::PH_STOP;
              stop_state_next = elfnsp_pkg::STATUS_TRUNC;
            end else begin
              for (int k = 0; k < NC; k++) begin
                match_flags_next[k] =
                  (name_length_next == WW'(elfnsp_pkg::known_len(3'(k)))) ||
                  (name_length_next == WW'(elfnsp_pkg::known_len(3'(k))) + WW'(1));
              end
              complete_c = (name_length_next == '0) && (desc_length_next == '0);
              field_count_next = '0;
              phase_next = enter_after(2'd0, name_length_next, desc_length_next,
                                       bl_dec != '0);
            end
          end
        end
        elfnsp_pkg::PH_NAME: begin
          role_c = elfnsp_pkg::ROLE_NAME;
          for (int k = 0; k < NC; k++) begin
            if (match_flags[k]) begin
              if (XW'(field_count) < XW'(elfnsp_pkg::known_len(3'(k)))) begin
                if (data_byte != elfnsp_pkg::known_char(3'(k), field_count[3:0])) begin
                  match_flags_next[k] = 1'b0;
                end
              end else if (data_byte != 8'd0) begin
                match_flags_next[k] = 1'b0;
              end
            end
          end
          field_count_next = fc_inc;
          ntype_c = type_word;
          dsize_c = desc_length;
          if (XW'(fc_inc) == XW'(name_length)) begin
            cls_c      = elfnsp_pkg::class_of(match_flags_next);
            complete_c = (desc_length == '0);
            field_count_next = '0;
            phase_next = enter_after(2'd1, name_length, desc_length, bl_dec != '0);
          end
        end
        elfnsp_pkg::PH_NPAD: begin
          role_c = elfnsp_pkg::ROLE_NAME_PAD;
          field_count_next = fc_inc;
          ntype_c = type_word;
          dsize_c = desc_length;
          cls_c   = elfnsp_pkg::class_of(match_flags);
          if (XW'(fc_inc) >= XW'(elfnsp_pkg::pad_of(name_length))) begin
            field_count_next = '0;
            phase_next = enter_after(2'd2, name_length, desc_length, bl_dec != '0);
          end
        end
        elfnsp_pkg::PH_DESC: begin
          role_c = elfnsp_pkg::ROLE_DESC;
          doff_c = WW'(field_count);
          field_count_next = fc_inc;
          ntype_c = type_word;
          dsize_c = desc_length;
          cls_c   = elfnsp_pkg::class_of(match_flags);
          if (XW'(fc_inc) == XW'(desc_length)) begin
            complete_c = 1'b1;
            field_count_next = '0;
            phase_next = enter_after(2'd3, name_length, desc_length, bl_dec != '0);
          end
        end
        elfnsp_pkg::PH_DPAD: begin
          role_c = elfnsp_pkg::ROLE_DESC_PAD;
          field_count_next = fc_inc;
          ntype_c = type_word;
          dsize_c = desc_length;
          cls_c   = elfnsp_pkg::class_of(match_flags);
          // padding running past the region is clipped
          if (XW'(fc_inc) >= XW'(elfnsp_pkg::pad_of(desc_length)) || bl_dec == '0) begin
            phase_next       = elfnsp_pkg::PH_HDR;
            field_count_next = '0;
          end
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
  end

  // region size saturated to the counter width
  always_comb begin
    sat_size = XW'(cfg_data);
    if (sat_size > XW'({CW{1'b1}})) begin
      sat_size = XW'({CW{1'b1}});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      big_endian    <= 1'b0;
      phase         <= elfnsp_pkg::PH_HDR;
      field_count   <= '0;
      bytes_left    <= '0;
      word_assembly <= '0;
      name_length   <= '0;
      desc_length   <= '0;
      type_word     <= '0;
      match_flags   <= '1;
      stop_state    <= elfnsp_pkg::STATUS_RUNNING;
    end else begin
      if (byte_xfer) begin
        phase         <= phase_next;
        field_count   <= field_count_next;
        bytes_left    <= bytes_left_next;
        word_assembly <= word_assembly_next;
        name_length   <= name_length_next;
        desc_length   <= desc_length_next;
        type_word     <= type_word_next;
        match_flags   <= match_flags_next;
        stop_state    <= stop_state_next;
      end
      if (cfg_xfer) begin
        case (cfg_index)
          elfnsp_pkg::REG_BIG_ENDIAN: begin
            big_endian <= cfg_data[0];
          end
          elfnsp_pkg::REG_REGION_SIZE: begin
            // restart the parse
            bytes_left    <= CW'(sat_size);
            phase         <= elfnsp_pkg::PH_HDR;
            field_count   <= '0;
            word_assembly <= '0;
            stop_state    <= elfnsp_pkg::STATUS_RUNNING;
          end
          default: begin
            big_endian <= big_endian;
          end
        endcase
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (byte_xfer) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_xfer) begin
      byte_role     <= role_c;
      note_type     <= ntype_c;
      name_class    <= cls_c;
      desc_size     <= dsize_c;
      desc_offset   <= doff_c;
      note_complete <= complete_c;
      parse_status  <= stop_state_next;
    end
  end

endmodule

// ===== test/tb_elf_note_stream_parser_unit.sv =====
// tb_elf_note_stream_parser_unit: byte-level checks of the note region parser,
// fed with generated note regions and random idle/stall on both channels
// depends on elfnsp_pkg and elf_note_stream_parser_unit
`timescale 1ns / 1ps

module tb_elf_note_stream_parser_unit;
  import elfnsp_pkg::*;

  localparam int QUIET_LIMIT = 1000;
  localparam int ITEM_TARGET = 1100;

  // indexes that decode to no register
  localparam logic [IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [IDX_W-1:0] REG_SPARE_B = 2'd3;

  // known note names, left aligned, one byte per character
  localparam logic [127:0] CHARS_VMCI    = {"VMCOREINFO", 48'h0};
  localparam logic [127:0] CHARS_VMCI_HV = {"VMCOREINFO_", 24'h58454e, 16'h0};
  localparam logic [127:0] CHARS_CORE    = {"CORE", 96'h0};
  localparam logic [127:0] CHARS_HV      = {24'h58656e, 104'h0};
  localparam logic [127:0] CHARS_NOTE_HV = {".note.", 24'h58656e, 56'h0};

  typedef struct packed {
    logic [ROLE_W-1:0]  role;
    logic [WORD_W-1:0]  ntype;
    logic [CLASS_W-1:0] cls;
    logic [WORD_W-1:0]  dsize;
    logic [WORD_W-1:0]  doff;
    logic               complete;
    logic [STAT_W-1:0]  status;
  } byte_label_t;

  function automatic int wanted_len(input int k);
    case (k)
      0: return 10;
      1: return 14;
      2: return 4;
      3: return 3;
      default: return 9;
    endcase
  endfunction

  function automatic logic [7:0] wanted_char(input int k, input int i);
    logic [127:0] s;
    case (k)
      0: s = CHARS_VMCI;
      1: s = CHARS_VMCI_HV;
      2: s = CHARS_CORE;
      3: s = CHARS_HV;
      default: s = CHARS_NOTE_HV;
    endcase
    return s[127 - 8 * i -: 8];
  endfunction

  function automatic logic [1:0] pad4(input logic [WORD_W-1:0] n);
    return ~n[1:0] + 2'd1;
  endfunction

  class note_label_board;
    logic                  big_end;
    phase_t                phase;
    logic [WORD_W-1:0]     field_cnt;
    logic [WORD_W-1:0]     bytes_left;
    logic [WORD_W-1:0]     word_acc;
    logic [WORD_W-1:0]     name_len;
    logic [WORD_W-1:0]     desc_len;
    logic [WORD_W-1:0]     type_word;
    logic [NAME_COUNT-1:0] match;
    logic [STAT_W-1:0]     stop_code;
    byte_label_t           expected_labels[$];
    int                    errors;

    function new();
      big_end    = 1'b0;
      phase      = PH_HDR;
      field_cnt  = '0;
      bytes_left = '0;
      word_acc   = '0;
      name_len   = '0;
      desc_len   = '0;
      type_word  = '0;
      match      = '1;
      stop_code  = STATUS_RUNNING;
      errors     = 0;
    endfunction

    function int pending();
      return expected_labels.size();
    endfunction

    function void apply_reg(input logic [IDX_W-1:0] idx, input logic [WORD_W-1:0] d);
      if (idx == REG_BIG_ENDIAN) begin
        big_end = d[0];
      end else if (idx == REG_REGION_SIZE) begin
        bytes_left = d;
        phase      = PH_HDR;
        field_cnt  = '0;
        word_acc   = '0;
        stop_code  = STATUS_RUNNING;
      end
    endfunction

    function logic [CLASS_W-1:0] best_class();
      for (int k = 0; k < NAME_COUNT; k++) begin
        if (match[k]) begin
          return CLASS_W'(k + 1);
        end
      end
      return CLASS_OTHER;
    endfunction

    // first non-empty section after section p
    function void advance_from(input phase_t p);
      field_cnt = '0;
      if (p < PH_NAME && name_len != 0) begin
        phase = PH_NAME;
      end else if (p < PH_NPAD && pad4(name_len) != 2'd0) begin
        phase = PH_NPAD;
      end else if (p < PH_DESC && desc_len != 0) begin
        phase = PH_DESC;
      end else if (p < PH_DPAD && pad4(desc_len) != 2'd0 && bytes_left != 0) begin
        phase = PH_DPAD;
      end else begin
        phase = PH_HDR;
      end
    endfunction

    function void note_byte(input logic [7:0] b);
      byte_label_t       r;
      logic [WORD_W-1:0] v;
      logic [33:0]       need;
      logic [7:0]        want;
      r = '0;
      r.role = ROLE_IGNORED;
      if (phase == PH_STOP) begin
        // stopped: nothing but the status
      end else if (phase == PH_HDR && field_cnt == 0 && bytes_left < HDR_BYTES) begin
        phase = PH_STOP;
        stop_code = STATUS_CLEAN;
      end else begin
        if (bytes_left != 0) begin
          bytes_left--;
        end
        if (phase != PH_HDR) begin
          r.ntype = type_word;
          r.dsize = desc_len;
        end
        case (phase)
          PH_HDR: begin
            r.role = ROLE_HEADER;
            word_acc = {word_acc[23:0], b};
            if (field_cnt[1:0] == 2'd3) begin
              v = big_end ? word_acc
                          : {word_acc[7:0], word_acc[15:8], word_acc[23:16], word_acc[31:24]};
              case (field_cnt >> 2)
                0: name_len = v;
                1: desc_len = v;
                default: type_word = v;
              endcase
            end
            field_cnt++;
            if (field_cnt == HDR_BYTES) begin
              need = {2'b0, name_len} + 34'(pad4(name_len)) + {2'b0, desc_len};
              r.ntype = type_word;
              r.dsize = desc_len;
              if ({2'b0, bytes_left} < need) begin
                phase = PH_STOP;
                stop_code = STATUS_TRUNC;
              end else begin
                match = '0;
                for (int k = 0; k < NAME_COUNT; k++) begin
                  if (name_len == wanted_len(k) || name_len == wanted_len(k) + 1) begin
                    match[k] = 1'b1;
                  end
                end
                r.complete = (name_len == 0 && desc_len == 0);
                advance_from(PH_HDR);
              end
            end
          end
          PH_NAME: begin
            r.role = ROLE_NAME;
            for (int k = 0; k < NAME_COUNT; k++) begin
              want = (field_cnt < wanted_len(k)) ? wanted_char(k, int'(field_cnt)) : 8'h00;
              if (match[k] && b != want) begin
                match[k] = 1'b0;
              end
            end
            field_cnt++;
            if (field_cnt == name_len) begin
              r.cls = best_class();
              r.complete = (desc_len == 0);
              advance_from(PH_NAME);
            end
          end
          PH_NPAD: begin
            r.role = ROLE_NAME_PAD;
            r.cls = best_class();
            field_cnt++;
            if (field_cnt >= WORD_W'(pad4(name_len))) begin
              advance_from(PH_NPAD);
            end
          end
          PH_DESC: begin
            r.role = ROLE_DESC;
            r.cls = best_class();
            r.doff = field_cnt;
            field_cnt++;
            if (field_cnt == desc_len) begin
              r.complete = 1'b1;
              advance_from(PH_DESC);
            end
          end
          default: begin
            r.role = ROLE_DESC_PAD;
            r.cls = best_class();
            field_cnt++;
            // padding that runs past the region is clipped
            if (field_cnt >= WORD_W'(pad4(desc_len)) || bytes_left == 0) begin
              phase = PH_HDR;
              field_cnt = '0;
            end
          end
        endcase
      end
      r.status = stop_code;
      expected_labels.push_back(r);
    endfunction

    function void cmp_field(input string name, input logic [WORD_W-1:0] exp,
                            input logic [WORD_W-1:0] act);
      if (exp !== act) begin
        $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp, act);
        errors++;
      end
    endfunction

    function void check_label(input byte_label_t got);
      byte_label_t exp;
      if (expected_labels.size() == 0) begin
        $error("result transfer with no byte outstanding");
        errors++;
        return;
      end
      exp = expected_labels.pop_front();
      cmp_field("byte_role", WORD_W'(exp.role), WORD_W'(got.role));
      cmp_field("note_type", exp.ntype, got.ntype);
      cmp_field("name_class", WORD_W'(exp.cls), WORD_W'(got.cls));
      cmp_field("desc_size", exp.dsize, got.dsize);
      cmp_field("desc_offset", exp.doff, got.doff);
      cmp_field("note_complete", WORD_W'(exp.complete), WORD_W'(got.complete));
      cmp_field("parse_status", WORD_W'(exp.status), WORD_W'(got.status));
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [IDX_W-1:0]   cfg_index;
  logic [WORD_W-1:0]  cfg_data;
  logic               byte_valid;
  logic               byte_stall;
  logic [7:0]         data_byte;
  logic               result_valid;
  logic               result_stall;
  logic [ROLE_W-1:0]  byte_role;
  logic [WORD_W-1:0]  note_type;
  logic [CLASS_W-1:0] name_class;
  logic [WORD_W-1:0]  desc_size;
  logic [WORD_W-1:0]  desc_offset;
  logic               note_complete;
  logic [STAT_W-1:0]  parse_status;

  note_label_board board = new();
  logic [7:0]      region_q[$];
  logic            no_idle = 1'b0;
  int              items_sent = 0;
  int              quiet = 0;

  elf_note_stream_parser_unit dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .data_byte    (data_byte),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .byte_role    (byte_role),
    .note_type    (note_type),
    .name_class   (name_class),
    .desc_size    (desc_size),
    .desc_offset  (desc_offset),
    .note_complete(note_complete),
    .parse_status (parse_status)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (byte_valid && !byte_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet + 1 >= QUIET_LIMIT) begin
        $display("FAIL elf_note_stream_parser_unit");
        $finish;
      end
    end
  end

  function automatic int draw_gap();
    return no_idle ? 0 : int'($urandom_range(0, 9));
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    byte_valid <= 1'b1;
    data_byte  <= b;
    do @(posedge clk); while (byte_stall);
    board.note_byte(b);
    items_sent++;
    @(negedge clk);
  endtask

  // sender holds off until every result is back
  task automatic quiesce();
    byte_valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [WORD_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    board.apply_reg(idx, d);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic void push_word(input logic [WORD_W-1:0] w, input logic be);
    if (be) begin
      for (int i = 3; i >= 0; i--) region_q.push_back(w[8*i +: 8]);
    end else begin
      for (int i = 0; i < 4; i++) region_q.push_back(w[8*i +: 8]);
    end
  endfunction

  task automatic feed_region(input int flip_at);
    foreach (region_q[i]) begin
      if (i == flip_at) begin
        // byte order changed in the middle of the stream
        quiesce();
        write_reg(REG_BIG_ENDIAN, $urandom);
      end
      send_byte(region_q[i]);
    end
  endtask

  // appends one note; content counts name, name pad and descriptor bytes
  task automatic add_note(input logic be, output int content, output int dpad);
    int         sel;
    int         k;
    int         dsz;
    int         npad;
    logic [7:0] name_b[$];
    sel = $urandom_range(0, 7);
    k = (sel <= 4) ? sel : int'($urandom_range(0, 4));
    if (sel <= 4 || sel == 7) begin
      for (int i = 0; i < wanted_len(k); i++) name_b.push_back(wanted_char(k, i));
      if (sel == 7) begin
        sel = $urandom_range(0, wanted_len(k) - 1);
        name_b[sel] = name_b[sel] ^ 8'($urandom_range(1, 255));
      end
      if ($urandom_range(0, 1)) name_b.push_back(8'h00);
    end else if (sel == 6) begin
      repeat ($urandom_range(1, 18)) name_b.push_back(8'($urandom));
    end
    dsz = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 40))
                                      : int'($urandom_range(0, 12));
    npad = int'(pad4(name_b.size()));
    dpad = int'(pad4(dsz));
    push_word(name_b.size(), be);
    push_word(dsz, be);
    push_word($urandom, be);
    foreach (name_b[i]) region_q.push_back(name_b[i]);
    repeat (npad + dsz + dpad) region_q.push_back(8'($urandom));
    content = name_b.size() + npad + dsz;
  endtask

  task automatic run_region();
    int                content;
    int                dpad;
    int                total;
    int                flip_at;
    int                extra;
    logic              be;
    logic [WORD_W-1:0] rsize;
    logic [WORD_W-1:0] d;
    region_q.delete();
    be = 1'($urandom_range(0, 1));
    repeat ($urandom_range(1, 4)) add_note(be, content, dpad);
    total = region_q.size();
    rsize = total;
    case ($urandom_range(0, 9))
      4: begin
        // short tail: ends cleanly at the next header
        extra = $urandom_range(1, 11);
        repeat (extra) region_q.push_back(8'($urandom));
        rsize = total + extra;
      end
      5: if (dpad > 0) rsize = total - $urandom_range(1, dpad);
      6: if (content > 0) rsize = total - dpad - $urandom_range(1, content);
      7: begin
        extra = $urandom_range(12, 30);
        repeat (extra) region_q.push_back(8'($urandom));
        rsize = total + extra;
      end
      default: ;
    endcase
    repeat ($urandom_range(0, 3)) region_q.push_back(8'($urandom));
    flip_at = ($urandom_range(0, 7) == 0) ? int'($urandom_range(1, region_q.size() - 1)) : -1;
    quiesce();
    no_idle = ($urandom_range(0, 3) == 0);
    d = $urandom;
    d[0] = be;
    write_reg(REG_BIG_ENDIAN, d);
    if ($urandom_range(0, 7) == 0) begin
      write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, $urandom);
    end
    write_reg(REG_REGION_SIZE, rsize);
    feed_region(flip_at);
  endtask

  initial begin : result_sink
    int          gap;
    byte_label_t got;
    result_stall = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        result_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      result_stall <= 1'b0;
      do @(posedge clk); while (!result_valid);
      got.role     = byte_role;
      got.ntype    = note_type;
      got.cls      = name_class;
      got.dsize    = desc_size;
      got.doff     = desc_offset;
      got.complete = note_complete;
      got.status   = parse_status;
      board.check_label(got);
      @(negedge clk);
    end
  end

  initial begin
    rst        = 1'b1;
    cfg_valid  = 1'b0;
    cfg_index  = REG_BIG_ENDIAN;
    cfg_data   = '0;
    byte_valid = 1'b0;
    data_byte  = 8'h00;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty region out of reset, then an explicit zero size
    send_byte(8'h00);
    quiesce();
    write_reg(REG_REGION_SIZE, '0);
    send_byte(8'hff);

    // largest region, name size that cannot fit: truncated on the last header byte
    quiesce();
    write_reg(REG_BIG_ENDIAN, 32'h1);
    write_reg(REG_REGION_SIZE, '1);
    region_q.delete();
    push_word('1, 1'b1);
    push_word('0, 1'b1);
    push_word('1, 1'b1);
    feed_region(-1);

    // unused indexes, then a huge descriptor cut short by a restart
    quiesce();
    write_reg(REG_SPARE_A, '1);
    write_reg(REG_SPARE_B, '0);
    write_reg(REG_BIG_ENDIAN, '0);
    write_reg(REG_REGION_SIZE, '1);
    region_q.delete();
    push_word(32'd4, 1'b0);
    push_word(32'h1000_0000, 1'b0);
    push_word(32'h0, 1'b0);
    for (int i = 0; i < 4; i++) region_q.push_back(wanted_char(2, i));
    region_q.push_back(8'hc3);
    feed_region(-1);

    while (items_sent < ITEM_TARGET) run_region();

    byte_valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    if (board.errors == 0) begin
      $display("PASS elf_note_stream_parser_unit");
    end else begin
      $display("FAIL elf_note_stream_parser_unit");
    end
    $finish;
  end

endmodule
